[hw/rtl/twq_pkg.sv]
// Shared constants, action codes and controller/datapath link types for the wait queue.
package twq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W = 16;
    localparam int OCC_W  = 5;
    localparam int ACT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIND    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch a new word, rewind the walk
        logic step;    // visit one entry
        logic finish;  // write tail / settle total, push final result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic walk_end;   // every entry visited
        logic needs_out;  // the next step pushes a result
        logic out_free;   // output register can take a result this cycle
    } t_status;

endpackage

[hw/rtl/twq_ctrl.sv]
// Sequencer for the wait queue: accept, walk the entries, issue the final result.
module twq_ctrl import twq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [ACT_W-1:0] i_action,
    input  t_status          i_status,
    output t_cmd             o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       walk_op;

    assign walk_op = i_action inside {ACT_DEQUEUE, ACT_FIND, ACT_DELETE, ACT_TICK};
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = walk_op ? S_WALK : S_DONE;
                end
            end
            S_WALK: begin
                if (i_status.walk_end) begin
                    n_state = S_DONE;
                end else if (!i_status.needs_out || i_status.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.load, o_cmd.step, o_cmd.finish}) <= 1)
        else $error("twq_ctrl: more than one command at once");

    a_finish_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("twq_ctrl: not idle after finish");

    a_step_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_status.needs_out) |-> i_status.out_free)
        else $error("twq_ctrl: step pushed into a busy output register");

endmodule

[hw/rtl/twq_datapath.sv]
// Entry store, compacting walk and output register of the wait queue.
module twq_datapath import twq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [15:0]       i_thread_id,
    input  logic [TICK_W-1:0] i_wait_ticks,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [15:0]       o_result_id,
    output logic              o_hit,
    output logic              o_full_drop,
    output logic [OCC_W-1:0]  o_occupancy,
    output logic [OCC_W-1:0]  o_woken_total,
    output logic              o_last
);

    // entry store, no reset: only entries below r_total are read
    logic [ID_BITS-1:0] r_ids  [QUEUE_DEPTH];
    logic [TICK_W-1:0]  r_cnts [QUEUE_DEPTH];

    logic [CNT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_wr;
    logic [ACT_W-1:0]   r_op;
    logic [ID_BITS-1:0] r_id;
    logic [TICK_W-1:0]  r_ticks;
    logic [ID_BITS-1:0] r_res_id;
    logic               r_found;
    logic [CNT_W-1:0]   r_woken;
    logic               r_pend_valid;
    logic [ID_BITS-1:0] r_pend_id;
    logic [CNT_W-1:0]   r_pend_occ;

    logic               r_out_valid;
    logic [15:0]        r_out_id;
    logic               r_out_hit;
    logic               r_out_drop;
    logic [OCC_W-1:0]   r_out_occ;
    logic [OCC_W-1:0]   r_out_woken;
    logic               r_out_last;

    logic [ID_BITS-1:0] rd_id;
    logic [TICK_W-1:0]  rd_cnt;
    logic [TICK_W-1:0]  dec_cnt;
    logic               id_match;
    logic               drop;
    logic               woke;
    logic               out_free;
    logic               we;
    logic [IDX_W-1:0]   wa;
    logic [ID_BITS-1:0] wd_id;
    logic [TICK_W-1:0]  wd_cnt;
    logic               full;
    logic [CNT_W-1:0]   woke_occ;

    logic               push;
    logic [15:0]        push_id;
    logic               push_hit;
    logic               push_drop;
    logic [OCC_W-1:0]   push_occ;
    logic [OCC_W-1:0]   push_woken;
    logic               push_last;

    assign rd_id    = r_ids[r_idx[IDX_W-1:0]];
    assign rd_cnt   = r_cnts[r_idx[IDX_W-1:0]];
    assign dec_cnt  = (rd_cnt != '0) ? rd_cnt - TICK_W'(1) : rd_cnt;
    assign id_match = (rd_id == r_id);
    assign woke     = (r_op == ACT_TICK) && (dec_cnt == '0);
    assign full     = (r_total >= CNT_W'(QUEUE_DEPTH));
    assign out_free = !r_out_valid || i_out_ready;
    // occupancy once this entry leaves: kept so far plus those not yet visited
    assign woke_occ = r_wr + r_total - r_idx - CNT_W'(1);

    always_comb begin
        drop = 1'b0;
        case (r_op)
            ACT_DEQUEUE: drop = (r_idx == '0);
            ACT_DELETE:  drop = !r_found && id_match;
            ACT_TICK:    drop = woke;
            default:     drop = 1'b0;
        endcase
    end

    assign o_status.walk_end  = (r_idx == r_total);
    assign o_status.needs_out = woke && r_pend_valid;
    assign o_status.out_free  = out_free;

    // single write port: compaction during the walk, tail on enqueue finish
    always_comb begin
        we     = 1'b0;
        wa     = r_wr[IDX_W-1:0];
        wd_id  = rd_id;
        wd_cnt = (r_op == ACT_TICK) ? dec_cnt : rd_cnt;
        if (i_cmd.step && !drop) begin
            we = 1'b1;
        end else if (i_cmd.finish && (r_op == ACT_ENQUEUE) && !full) begin
            we     = 1'b1;
            wa     = r_total[IDX_W-1:0];
            wd_id  = r_id;
            wd_cnt = r_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ids[wa]  <= wd_id;
            r_cnts[wa] <= wd_cnt;
        end
    end

    // result push: an earlier woken entry during the walk, or the final word
    always_comb begin
        push       = 1'b0;
        push_id    = '0;
        push_hit   = 1'b0;
        push_drop  = 1'b0;
        push_occ   = OCC_W'(r_total);
        push_woken = '0;
        push_last  = 1'b0;
        if (i_cmd.step && woke && r_pend_valid) begin
            push     = 1'b1;
            push_id  = 16'(r_pend_id);
            push_hit = 1'b1;
            push_occ = OCC_W'(r_pend_occ);
        end else if (i_cmd.finish) begin
            push      = 1'b1;
            push_last = 1'b1;
            case (r_op)
                ACT_ENQUEUE: begin
                    if (full) begin
                        push_drop = 1'b1;
                    end else begin
                        push_id  = 16'(r_id);
                        push_hit = 1'b1;
                        push_occ = OCC_W'(r_total + CNT_W'(1));
                    end
                end
                ACT_DEQUEUE, ACT_DELETE: begin
                    push_hit = r_found;
                    push_id  = r_found ? 16'(r_res_id) : 16'd0;
                    push_occ = OCC_W'(r_wr);
                end
                ACT_FIND: begin
                    push_hit = r_found;
                    push_id  = r_found ? 16'(r_res_id) : 16'd0;
                end
                ACT_TICK: begin
                    if (r_pend_valid) begin
                        push_id    = 16'(r_pend_id);
                        push_hit   = 1'b1;
                        push_occ   = OCC_W'(r_pend_occ);
                        push_woken = OCC_W'(r_woken);
                    end else begin
                        push_occ = OCC_W'(r_wr);
                    end
                end
                default: push_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_idx        <= '0;
            r_wr         <= '0;
            r_op         <= ACT_ENQUEUE;
            r_found      <= 1'b0;
            r_woken      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op         <= i_action;
                r_idx        <= '0;
                r_wr         <= '0;
                r_found      <= 1'b0;
                r_woken      <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + CNT_W'(1);
                if (!drop) begin
                    r_wr <= r_wr + CNT_W'(1);
                end
                if (((r_op == ACT_FIND) && id_match) || ((r_op != ACT_TICK) && drop)) begin
                    r_found <= 1'b1;
                end
                if (woke) begin
                    r_woken      <= r_woken + CNT_W'(1);
                    r_pend_valid <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
                case (r_op)
                    ACT_ENQUEUE: if (!full) r_total <= r_total + CNT_W'(1);
                    ACT_DEQUEUE, ACT_DELETE, ACT_TICK: r_total <= r_wr;
                    default: r_total <= r_total;
                endcase
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id     <= ID_BITS'(i_thread_id);
            r_res_id <= ID_BITS'(i_thread_id);
            r_ticks  <= i_wait_ticks;
        end
        if (i_cmd.step && (r_op == ACT_DEQUEUE) && drop) begin
            r_res_id <= rd_id;
        end
        if (i_cmd.step && woke) begin
            r_pend_id  <= rd_id;
            r_pend_occ <= woke_occ;
        end
        if (push) begin
            r_out_id    <= push_id;
            r_out_hit   <= push_hit;
            r_out_drop  <= push_drop;
            r_out_occ   <= push_occ;
            r_out_woken <= push_woken;
            r_out_last  <= push_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_id   = r_out_id;
    assign o_hit         = r_out_hit;
    assign o_full_drop   = r_out_drop;
    assign o_occupancy   = r_out_occ;
    assign o_woken_total = r_out_woken;
    assign o_last        = r_out_last;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(QUEUE_DEPTH))
        else $error("twq_datapath: occupancy above depth");

    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_idx)
        else $error("twq_datapath: write pointer overtook read pointer");

    a_pend_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_op == ACT_TICK))
        else $error("twq_datapath: pending wake outside a tick");

    a_no_push_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("twq_datapath: result pushed over an untaken one");

endmodule

[hw/rtl/timed_wait_queue.sv]
// Top level of the timed wait queue: stream ports, sequencer and datapath.
//
// Usage: one input word per action on the s_axis side (action in tuser,
// thread id and wait count in tdata). Every word gives one result word on
// the m_axis side, except a tick, which gives one word per woken thread in
// queue order (tlast and the wake total on the last) or a single miss word
// when nothing wakes.
// Timing: enqueue and unused actions go from accept straight to the done
// state and then into the result register. Dequeue, find, delete and tick
// walk the stored entries one per cycle, pausing while a wake waits on the
// output register, through one read port and one write port. A new word is
// accepted only after the previous one has issued its last result;
// s_axis_tready rises as that result enters the output register.
// Reset: synchronous, active low; the queue comes up empty and no result
// is pending. Entry contents are not cleared, only the fill count.
// Back-pressure: one output register; while m_axis_tready is low and a
// result waits, the walk pauses at the next wake and the final result
// waits, so nothing is lost or repeated.
module timed_wait_queue import twq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] thread_id, [31:16] wait_ticks
    input  logic [2:0]  s_axis_tuser,   // [2:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] result_id, [20:16] occupancy,
                                        // [25:21] woken_total, [31:26] zero
    output logic [1:0]  m_axis_tuser,   // [0] hit, [1] full_drop
    output logic        m_axis_tlast
);

    t_cmd             cmd;
    t_status          status;
    logic [15:0]      result_id;
    logic [OCC_W-1:0] occupancy;
    logic [OCC_W-1:0] woken_total;

    twq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_status (status),
        .o_cmd    (cmd)
    );

    twq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (s_axis_tuser),
        .i_thread_id   (s_axis_tdata[15:0]),
        .i_wait_ticks  (s_axis_tdata[31:16]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_result_id   (result_id),
        .o_hit         (m_axis_tuser[0]),
        .o_full_drop   (m_axis_tuser[1]),
        .o_occupancy   (occupancy),
        .o_woken_total (woken_total),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, woken_total, occupancy, result_id};

endmodule

[tb/sv/twq_shadow_check.sv]
// Shadow copy of the wait queue: predicts every result word and checks the output stream.
module twq_shadow_check import twq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // [15:0] thread_id, [31:16] wait_ticks
    input  logic [2:0]  i_in_user,    // [2:0] action
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // [15:0] result_id, [20:16] occupancy,
                                      // [25:21] woken_total, [31:26] zero
    input  logic [1:0]  i_out_user,   // [0] hit, [1] full_drop
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_words_owed
);

    localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_BITS) - 64'd1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [15:0]      id;
        logic             hit;
        logic             drop;
        logic [OCC_W-1:0] occ;
        logic [OCC_W-1:0] woken;
        logic             last;
    } t_result;

    logic [15:0]       shadow_ids   [QUEUE_DEPTH];
    logic [TICK_W-1:0] shadow_counts[QUEUE_DEPTH];
    int                shadow_total = 0;
    t_result           words_owed[$];
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic string result_text(t_result r);
        return $sformatf("id %h hit %b drop %b occ %0d woken %0d last %b",
                         r.id, r.hit, r.drop, r.occ, r.woken, r.last);
    endfunction

    task automatic owe(logic [15:0] id, logic hit, logic drop, int occ, int woken,
                       logic last);
        words_owed.push_back('{id: id, hit: hit, drop: drop, occ: OCC_W'(occ),
                               woken: OCC_W'(woken), last: last});
    endtask

    // close the gap left at pos, keeping the order of the rest
    task automatic drop_entry(int pos);
        for (int i = pos; i + 1 < shadow_total; i++) begin
            shadow_ids[i]    = shadow_ids[i + 1];
            shadow_counts[i] = shadow_counts[i + 1];
        end
        shadow_total--;
    endtask

    task automatic apply_action(logic [ACT_W-1:0] act, logic [15:0] id,
                                logic [TICK_W-1:0] wait_cnt);
        t_result           woke[QUEUE_DEPTH];
        int                n_woke;
        int                keep;
        int                pos;
        logic [15:0]       head;
        logic [TICK_W-1:0] c;
        n_woke = 0;
        keep   = 0;
        pos    = -1;
        for (int i = 0; i < shadow_total; i++)
            if (pos < 0 && shadow_ids[i] == id) pos = i;
        case (act)
            ACT_ENQUEUE: begin
                if (shadow_total >= QUEUE_DEPTH) begin
                    owe(16'h0, 1'b0, 1'b1, shadow_total, 0, 1'b1);
                end else begin
                    shadow_ids[shadow_total]    = id;
                    shadow_counts[shadow_total] = wait_cnt;
                    shadow_total++;
                    owe(id, 1'b1, 1'b0, shadow_total, 0, 1'b1);
                end
            end
            ACT_DEQUEUE: begin
                if (shadow_total == 0) begin
                    owe(16'h0, 1'b0, 1'b0, 0, 0, 1'b1);
                end else begin
                    head = shadow_ids[0];
                    drop_entry(0);
                    owe(head, 1'b1, 1'b0, shadow_total, 0, 1'b1);
                end
            end
            ACT_FIND: begin
                if (pos >= 0) owe(id, 1'b1, 1'b0, shadow_total, 0, 1'b1);
                else          owe(16'h0, 1'b0, 1'b0, shadow_total, 0, 1'b1);
            end
            ACT_DELETE: begin
                if (pos >= 0) begin
                    drop_entry(pos);
                    owe(id, 1'b1, 1'b0, shadow_total, 0, 1'b1);
                end else begin
                    owe(16'h0, 1'b0, 1'b0, shadow_total, 0, 1'b1);
                end
            end
            ACT_TICK: begin
                for (int i = 0; i < shadow_total; i++) begin
                    c = shadow_counts[i];
                    if (c != 0) c = c - 1'b1;
                    if (c == 0) begin
                        // occupancy: survivors so far plus entries still to visit
                        woke[n_woke] = '{id: shadow_ids[i], hit: 1'b1, drop: 1'b0,
                                         occ: OCC_W'(keep + shadow_total - i - 1),
                                         woken: '0, last: 1'b0};
                        n_woke++;
                    end else begin
                        shadow_ids[keep]    = shadow_ids[i];
                        shadow_counts[keep] = c;
                        keep++;
                    end
                end
                shadow_total = keep;
                if (n_woke == 0) begin
                    owe(16'h0, 1'b0, 1'b0, shadow_total, 0, 1'b1);
                end else begin
                    woke[n_woke - 1].woken = OCC_W'(n_woke);
                    woke[n_woke - 1].last  = 1'b1;
                    for (int k = 0; k < n_woke; k++) words_owed.push_back(woke[k]);
                end
            end
            default: owe(16'h0, 1'b0, 1'b0, shadow_total, 0, 1'b1);
        endcase
    endtask

    task automatic check_word();
        t_result got;
        t_result want;
        got = '{id: i_out_data[15:0], hit: i_out_user[0], drop: i_out_user[1],
                occ: i_out_data[20:16], woken: i_out_data[25:21], last: i_out_last};
        if (words_owed.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result word: %s", result_text(got));
        end else begin
            want = words_owed.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result mismatch: expected %s, got %s",
                             result_text(want), result_text(got));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_total = 0;
            words_owed.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_word();
            if (i_in_valid && i_in_ready)
                apply_action(i_in_user, i_in_data[15:0] & ID_MASK, i_in_data[31:16]);
        end
        o_words_owed <= words_owed.size();
    end

endmodule

[tb/sv/tb_timed_wait_queue.sv]
// Testbench top for the timed wait queue: stimulus, back-pressure, timeout and verdict.
module tb_timed_wait_queue import twq_pkg::*; ();

    // action codes the block ignores
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    localparam int IDLE_PCT      = 26;        // chance of a gap cycle on either side
    localparam int RANDOM_WORDS  = 200;
    localparam int MODE_FILL     = 0;
    localparam int MODE_DRAIN    = 1;
    localparam int MODE_MIX      = 2;
    localparam int POOL_SIZE     = 6;
    // room for a full walk at the depth and a stalled final word
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 16;
    // worst case ~220 words, each a full walk plus up to 16 stalled words and gaps: far below this
    localparam int CYCLE_LIMIT   = 200000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] thread_id, [31:16] wait_ticks
    logic [2:0]  s_axis_tuser  = '0;   // [2:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] result_id, [20:16] occupancy,
                                       // [25:21] woken_total, [31:26] zero
    logic [1:0]  m_axis_tuser;         // [0] hit, [1] full_drop
    logic        m_axis_tlast;

    logic        steady = 1'b0;        // both sides run without gaps
    int          cycle_count = 0;
    int          fail_count;
    int          words_owed;
    logic [15:0] id_pool[POOL_SIZE];   // small id set so find/delete hit often

    timed_wait_queue dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    twq_shadow_check shadow (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_words_owed (words_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, none during the steady stretch
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one word, with random gap cycles first, and return at the edge
    // where it is taken. Entered just after a rising edge; tvalid gets at
    // most one assignment per edge.
    task automatic send_word(logic [ACT_W-1:0] act, logic [15:0] id,
                             logic [TICK_W-1:0] wait_cnt);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {wait_cnt, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 99) < 80) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // mostly short waits so wakes are frequent; now and then the full range
    function automatic logic [TICK_W-1:0] pick_wait();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return TICK_W'($urandom_range(0, 3));
        if (roll < 90) return TICK_W'($urandom_range(0, 20));
        return TICK_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // thresholds: spare, enqueue, find, delete, dequeue; the rest are ticks
    function automatic logic [ACT_W-1:0] pick_action(int mode);
        int roll;
        int t_enq;
        int t_find;
        int t_del;
        int t_deq;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  begin t_enq = 73; t_find = 80; t_del = 85; t_deq = 90; end
            MODE_DRAIN: begin t_enq = 15; t_find = 30; t_del = 50; t_deq = 65; end
            default:    begin t_enq = 40; t_find = 52; t_del = 64; t_deq = 74; end
        endcase
        if (roll < 3)      return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        if (roll < t_enq)  return ACT_ENQUEUE;
        if (roll < t_find) return ACT_FIND;
        if (roll < t_del)  return ACT_DELETE;
        if (roll < t_deq)  return ACT_DEQUEUE;
        return ACT_TICK;
    endfunction

    initial begin
        int mode;
        mode = MODE_FILL;
        for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = 16'($urandom_range(0, 16'hFFFF));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // ignored codes, then dequeue, tick, find and delete on an empty queue
        send_word(ACT_SPARE_FIRST, 16'hFFFF, 16'hFFFF);
        send_word(ACT_SPARE_LAST,  16'h0000, 16'h0000);
        send_word(ACT_DEQUEUE,     16'h0000, 16'h0000);
        send_word(ACT_TICK,        16'h0000, 16'h0000);
        send_word(ACT_FIND,        16'h0000, 16'h0000);
        send_word(ACT_DELETE,      16'hFFFF, 16'h0000);
        // extremes of id and wait, plus a repeated id
        send_word(ACT_ENQUEUE,     16'h0000, 16'h0000);
        send_word(ACT_ENQUEUE,     16'hFFFF, 16'hFFFF);
        send_word(ACT_ENQUEUE,     16'h5A5A, 16'h0002);
        send_word(ACT_ENQUEUE,     16'h0000, 16'h0001);
        send_word(ACT_FIND,        16'h0000, 16'h0000);   // first of the two hits
        send_word(ACT_FIND,        16'hA5A5, 16'h0000);   // absent
        send_word(ACT_DELETE,      16'h0000, 16'h0000);   // takes the earlier one only
        send_word(ACT_ENQUEUE,     16'h1111, 16'h0000);   // zero wait: wakes next tick
        send_word(ACT_TICK,        16'h0000, 16'h0000);   // two wakes, from the middle and tail
        send_word(ACT_TICK,        16'h0000, 16'h0000);   // lone wake
        send_word(ACT_DEQUEUE,     16'h0000, 16'h0000);   // head is the long waiter
        send_word(ACT_DEQUEUE,     16'h0000, 16'h0000);

        // --- random ---
        // open by filling past the depth: overflow drops, then ticks wake in bulk
        for (int k = 0; k < QUEUE_DEPTH + 2; k++)
            send_word(ACT_ENQUEUE, pick_id(), TICK_W'($urandom_range(0, 2)));
        for (int k = 0; k < RANDOM_WORDS - QUEUE_DEPTH - 2; k++) begin
            if (k % 25 == 0) mode = $urandom_range(MODE_FILL, MODE_MIX);
            steady = (k >= 70 && k < 130);
            send_word(pick_action(mode), pick_id(), pick_wait());
        end
        steady = 1'b0;

        // --- drain ---
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && words_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/twq_pkg.sv
hw/rtl/twq_ctrl.sv
hw/rtl/twq_datapath.sv
hw/rtl/timed_wait_queue.sv
tb/sv/twq_shadow_check.sv
tb/sv/tb_timed_wait_queue.sv
